[hw/rtl/table_driven_fsm_engine_top_macros.svh]
// Assertion helpers for the table-driven state machine engine.
`ifndef TABLE_DRIVEN_FSM_ENGINE_TOP_MACROS_SVH
`define TABLE_DRIVEN_FSM_ENGINE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FSME_ASSERT(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("fsm engine check failed");
`define FSME_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fsm engine check failed");
`else
`define FSME_ASSERT(label, cond)
`define FSME_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hw/rtl/fsme_pkg.sv]
package fsme_pkg;

   localparam int unsigned NUM_STATES_DEF  = 16;
   localparam int unsigned NUM_EVENTS_DEF  = 16;
   localparam int unsigned NUM_ACTIONS_DEF = 64;
   localparam int unsigned QUEUE_DEPTH_DEF = 16;

   localparam int unsigned OP_W        = 3;
   localparam int unsigned STATE_W     = 4;
   localparam int unsigned EVENT_W     = 4;
   localparam int unsigned ACTION_W    = 6;
   localparam int unsigned STATUS_W    = 2;
   localparam int unsigned PHASE_W     = 2;
   localparam int unsigned COUNT_W     = 5;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 5;
   localparam int unsigned NUM_PHASES  = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_STATE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUEUE_LIMIT = 1'd1;

   localparam logic [COUNT_W-1:0] QUEUE_LIMIT_RESET = 5'd16;

   typedef enum logic [OP_W-1:0] {
      OP_ENQUEUE     = 3'd0,
      OP_STEP        = 3'd1,
      OP_WRITE_TRANS = 3'd2,
      OP_WRITE_STATE = 3'd3,
      OP_RESTART     = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [PHASE_W-1:0] {
      PHASE_EXIT  = 2'd0,
      PHASE_TRANS = 2'd1,
      PHASE_ENTER = 2'd2,
      PHASE_NONE  = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_QUEUE,
      SEQ_TRANS,
      SEQ_ENTER,
      SEQ_EMIT
   } seq_type;

   function automatic int unsigned addr_width(int unsigned depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   function automatic logic action_live(logic [ACTION_W-1:0] code,
                                        int unsigned num_actions);
      return (code != '0) && (int'(code) < num_actions);
   endfunction

endpackage

[hw/rtl/fsme_ram.sv]
module fsme_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [fsme_pkg::addr_width(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [fsme_pkg::addr_width(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/table_driven_fsm_engine_top.sv]
// Enqueue, table writes, restart, empty step: one result, registered in the cycle after accept;
// one item a cycle unless the output stalls. Step on a non-empty queue: after the queue,
// transition and enter states, one result a cycle unless the output stalls; the wait before
// them is set by three dependent memory reads (queue, transition, state).
// Reset (synchronous) clears state, pointers, fill, sequencer and output valid; queue and
// table memories keep no reset and hold nothing defined until written. No clearing pass.
`include "table_driven_fsm_engine_top_macros.svh"

module table_driven_fsm_engine_top #(
   parameter int unsigned NUM_STATES  = fsme_pkg::NUM_STATES_DEF,
   parameter int unsigned NUM_EVENTS  = fsme_pkg::NUM_EVENTS_DEF,
   parameter int unsigned NUM_ACTIONS = fsme_pkg::NUM_ACTIONS_DEF,
   parameter int unsigned QUEUE_DEPTH = fsme_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [fsme_pkg::OP_W-1:0]            req_operation,
   input  logic [fsme_pkg::EVENT_W-1:0]         req_event_req,
   input  logic [fsme_pkg::STATE_W-1:0]         req_state_index,
   input  logic [fsme_pkg::STATE_W-1:0]         req_target_state,
   input  logic [fsme_pkg::ACTION_W-1:0]        req_transition_action,
   input  logic [fsme_pkg::ACTION_W-1:0]        req_exit_action,
   input  logic [fsme_pkg::ACTION_W-1:0]        req_enter_action,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [fsme_pkg::STATUS_W-1:0]        rsp_status,
   output logic [fsme_pkg::ACTION_W-1:0]        rsp_action_code,
   output logic [fsme_pkg::PHASE_W-1:0]         rsp_action_phase,
   output logic [fsme_pkg::STATE_W-1:0]         rsp_current_state,
   output logic [fsme_pkg::COUNT_W-1:0]         rsp_queue_count,
   output logic                                 rsp_last,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fsme_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fsme_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int unsigned STATE_W  = fsme_pkg::STATE_W;
   localparam int unsigned EVENT_W  = fsme_pkg::EVENT_W;
   localparam int unsigned ACTION_W = fsme_pkg::ACTION_W;
   localparam int unsigned COUNT_W  = fsme_pkg::COUNT_W;
   localparam int unsigned NPH      = fsme_pkg::NUM_PHASES;
   localparam int unsigned SAW      = fsme_pkg::addr_width(NUM_STATES);
   localparam int unsigned TAW      = fsme_pkg::addr_width(NUM_STATES * NUM_EVENTS);
   localparam int unsigned QAW      = fsme_pkg::addr_width(QUEUE_DEPTH);
   localparam int unsigned TRANS_W  = STATE_W + ACTION_W;
   localparam int unsigned SACT_W   = 2 * ACTION_W;
   localparam int unsigned COUNT_MAX = (1 << COUNT_W) - 1;
   localparam logic [COUNT_W-1:0] LIMIT_CAP =
      COUNT_W'((QUEUE_DEPTH > COUNT_MAX) ? COUNT_MAX : QUEUE_DEPTH);

   // constant wrap tables for state and event codes
   logic [STATE_W-1:0] state_wrap [2**STATE_W];
   logic [EVENT_W-1:0] event_wrap [2**EVENT_W];

   for (genvar g = 0; g < 2**STATE_W; g++) begin : g_state_wrap
      localparam int unsigned WRAPPED = g % NUM_STATES;
      assign state_wrap[g] = STATE_W'(WRAPPED);
   end

   for (genvar g = 0; g < 2**EVENT_W; g++) begin : g_event_wrap
      localparam int unsigned WRAPPED = g % NUM_EVENTS;
      assign event_wrap[g] = EVENT_W'(WRAPPED);
   end

   fsme_pkg::seq_type seq_ff, seq_in;
   fsme_pkg::op_type  op;

   logic [STATE_W-1:0]  start_state_ff, start_state_in;
   logic [COUNT_W-1:0]  queue_limit_ff, queue_limit_in;
   logic [STATE_W-1:0]  current_state_ff, current_state_in;
   logic [COUNT_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [COUNT_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]  fill_ff, fill_in;
   logic [NPH-1:0]      pending_ff, pending_in;
   logic                changed_ff, changed_in;
   logic [ACTION_W-1:0] exit_ff, exit_in;
   logic [ACTION_W-1:0] tact_ff, tact_in;
   logic [ACTION_W-1:0] enter_ff, enter_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [fsme_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ACTION_W-1:0]          rsp_code_ff, rsp_code_in;
   logic [fsme_pkg::PHASE_W-1:0] rsp_phase_ff, rsp_phase_in;
   logic [STATE_W-1:0]           rsp_state_ff, rsp_state_in;
   logic [COUNT_W-1:0]           rsp_count_ff, rsp_count_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic [COUNT_W-1:0] limit;
   logic [COUNT_W-1:0] wr_ptr_inc, rd_ptr_inc;
   logic               req_fire, out_free;
   logic               step_go;
   logic [STATE_W-1:0] next_state;

   logic               q_we, q_re;
   logic [QAW-1:0]     q_waddr, q_raddr;
   logic [EVENT_W-1:0] q_rdata;
   logic               t_we, t_re;
   logic [TAW-1:0]     t_waddr, t_raddr;
   logic [TRANS_W-1:0] t_wdata, t_rdata;
   logic               s_we, s_re;
   logic [SAW-1:0]     s_waddr, s_raddr;
   logic [SACT_W-1:0]  s_wdata, s_rdata;

   logic [NPH-1:0]               pick_mask;
   logic [fsme_pkg::PHASE_W-1:0] pick_phase;
   logic [ACTION_W-1:0]          pick_code;
   logic                         pick_last;

   assign op        = fsme_pkg::op_type'(req_operation);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (seq_ff == fsme_pkg::SEQ_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;
   assign step_go   = req_fire && (op == fsme_pkg::OP_STEP) && (fill_ff != '0);
   assign csr_ready = 1'b1;

   assign limit = (queue_limit_ff == '0) ? COUNT_W'(1) :
                  ((queue_limit_ff > LIMIT_CAP) ? LIMIT_CAP : queue_limit_ff);

   assign wr_ptr_inc = (wr_ptr_ff + COUNT_W'(1) >= limit) ? '0 : wr_ptr_ff + COUNT_W'(1);
   assign rd_ptr_inc = (rd_ptr_ff + COUNT_W'(1) >= limit) ? '0 : rd_ptr_ff + COUNT_W'(1);

   assign next_state = state_wrap[t_rdata[TRANS_W-1 -: STATE_W]];

   // memory ports
   always_comb begin
      q_we    = req_fire && (op == fsme_pkg::OP_ENQUEUE) && (fill_ff < limit);
      q_waddr = QAW'(wr_ptr_ff);
      q_re    = req_fire && (op == fsme_pkg::OP_STEP);
      q_raddr = QAW'(rd_ptr_ff);

      t_we    = req_fire && (op == fsme_pkg::OP_WRITE_TRANS);
      t_waddr = TAW'(state_wrap[req_state_index]) * TAW'(NUM_EVENTS)
              + TAW'(event_wrap[req_event_req]);
      t_wdata = {req_target_state, req_transition_action};
      t_re    = (seq_ff == fsme_pkg::SEQ_QUEUE);
      t_raddr = TAW'(current_state_ff) * TAW'(NUM_EVENTS) + TAW'(event_wrap[q_rdata]);

      s_we    = req_fire && (op == fsme_pkg::OP_WRITE_STATE);
      s_waddr = SAW'(state_wrap[req_state_index]);
      s_wdata = {req_exit_action, req_enter_action};
      s_re    = q_re || (seq_ff == fsme_pkg::SEQ_TRANS);
      s_raddr = (seq_ff == fsme_pkg::SEQ_TRANS) ? SAW'(next_state) : SAW'(current_state_ff);
   end

   fsme_ram #(.WIDTH(EVENT_W), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (req_event_req),
      .rd_en   (q_re),
      .rd_addr (q_raddr),
      .rd_data (q_rdata)
   );

   fsme_ram #(.WIDTH(TRANS_W), .DEPTH(NUM_STATES * NUM_EVENTS)) u_trans_ram (
      .clock   (clock),
      .wr_en   (t_we),
      .wr_addr (t_waddr),
      .wr_data (t_wdata),
      .rd_en   (t_re),
      .rd_addr (t_raddr),
      .rd_data (t_rdata)
   );

   fsme_ram #(.WIDTH(SACT_W), .DEPTH(NUM_STATES)) u_state_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_en   (s_re),
      .rd_addr (s_raddr),
      .rd_data (s_rdata)
   );

   // oldest pending action first
   always_comb begin
      pick_mask  = '0;
      pick_phase = fsme_pkg::PHASE_NONE;
      pick_code  = '0;
      if (pending_ff[fsme_pkg::PHASE_EXIT]) begin
         pick_mask[fsme_pkg::PHASE_EXIT] = 1'b1;
         pick_phase = fsme_pkg::PHASE_EXIT;
         pick_code  = exit_ff;
      end else if (pending_ff[fsme_pkg::PHASE_TRANS]) begin
         pick_mask[fsme_pkg::PHASE_TRANS] = 1'b1;
         pick_phase = fsme_pkg::PHASE_TRANS;
         pick_code  = tact_ff;
      end else if (pending_ff[fsme_pkg::PHASE_ENTER]) begin
         pick_mask[fsme_pkg::PHASE_ENTER] = 1'b1;
         pick_phase = fsme_pkg::PHASE_ENTER;
         pick_code  = enter_ff;
      end else if (pending_ff[fsme_pkg::PHASE_NONE]) begin
         pick_mask[fsme_pkg::PHASE_NONE] = 1'b1;
      end
      pick_last = (pending_ff & ~pick_mask) == '0;
   end

   // next state
   always_comb begin
      seq_in = seq_ff;
      case (seq_ff)
         fsme_pkg::SEQ_IDLE: begin
            if (req_fire && (op == fsme_pkg::OP_STEP) && (fill_ff != '0)) begin
               seq_in = fsme_pkg::SEQ_QUEUE;
            end
         end
         fsme_pkg::SEQ_QUEUE: seq_in = fsme_pkg::SEQ_TRANS;
         fsme_pkg::SEQ_TRANS: seq_in = fsme_pkg::SEQ_ENTER;
         fsme_pkg::SEQ_ENTER: seq_in = fsme_pkg::SEQ_EMIT;
         fsme_pkg::SEQ_EMIT: begin
            if (out_free && pick_last) begin
               seq_in = fsme_pkg::SEQ_IDLE;
            end
         end
         default: seq_in = fsme_pkg::SEQ_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      logic live_exit, live_tact, live_enter;

      start_state_in   = start_state_ff;
      queue_limit_in   = queue_limit_ff;
      current_state_in = current_state_ff;
      wr_ptr_in        = wr_ptr_ff;
      rd_ptr_in        = rd_ptr_ff;
      fill_in          = fill_ff;
      pending_in       = pending_ff;
      changed_in       = changed_ff;
      exit_in          = exit_ff;
      tact_in          = tact_ff;
      enter_in         = enter_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_phase_in  = rsp_phase_ff;
      rsp_state_in  = rsp_state_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;

      live_exit  = changed_ff && fsme_pkg::action_live(exit_ff, NUM_ACTIONS);
      live_tact  = fsme_pkg::action_live(tact_ff, NUM_ACTIONS);
      live_enter = changed_ff && fsme_pkg::action_live(s_rdata[ACTION_W-1:0], NUM_ACTIONS);

      if (csr_valid && csr_ready) begin
         case (csr_index)
            fsme_pkg::CSR_START_STATE: start_state_in = STATE_W'(csr_wdata);
            fsme_pkg::CSR_QUEUE_LIMIT: queue_limit_in = csr_wdata;
            default: ;
         endcase
      end

      case (seq_ff)
         fsme_pkg::SEQ_IDLE: begin
            if (req_fire) begin
               rsp_status_in = fsme_pkg::STATUS_DONE;
               case (op)
                  fsme_pkg::OP_ENQUEUE: begin
                     if (fill_ff < limit) begin
                        wr_ptr_in = wr_ptr_inc;
                        fill_in   = fill_ff + COUNT_W'(1);
                     end else begin
                        rsp_status_in = fsme_pkg::STATUS_FULL;
                     end
                  end
                  fsme_pkg::OP_STEP: begin
                     if (fill_ff == '0) begin
                        rsp_status_in = fsme_pkg::STATUS_EMPTY;
                     end else begin
                        rd_ptr_in = rd_ptr_inc;
                        fill_in   = fill_ff - COUNT_W'(1);
                     end
                  end
                  fsme_pkg::OP_RESTART: begin
                     current_state_in = state_wrap[start_state_ff];
                     wr_ptr_in        = '0;
                     rd_ptr_in        = '0;
                     fill_in          = '0;
                  end
                  default: ;
               endcase
               if (!((op == fsme_pkg::OP_STEP) && (fill_ff != '0))) begin
                  rsp_valid_in = 1'b1;
                  rsp_code_in  = '0;
                  rsp_phase_in = fsme_pkg::PHASE_NONE;
                  rsp_state_in = current_state_in;
                  rsp_count_in = fill_in;
                  rsp_last_in  = 1'b1;
               end
            end
         end
         fsme_pkg::SEQ_QUEUE: begin
            exit_in = s_rdata[SACT_W-1 -: ACTION_W];
         end
         fsme_pkg::SEQ_TRANS: begin
            tact_in          = t_rdata[ACTION_W-1:0];
            changed_in       = next_state != current_state_ff;
            current_state_in = next_state;
         end
         fsme_pkg::SEQ_ENTER: begin
            enter_in = s_rdata[ACTION_W-1:0];
            pending_in[fsme_pkg::PHASE_EXIT]  = live_exit;
            pending_in[fsme_pkg::PHASE_TRANS] = live_tact;
            pending_in[fsme_pkg::PHASE_ENTER] = live_enter;
            pending_in[fsme_pkg::PHASE_NONE]  = !(live_exit || live_tact || live_enter);
         end
         fsme_pkg::SEQ_EMIT: begin
            if (out_free) begin
               pending_in    = pending_ff & ~pick_mask;
               rsp_valid_in  = 1'b1;
               rsp_status_in = fsme_pkg::STATUS_DONE;
               rsp_code_in   = pick_code;
               rsp_phase_in  = pick_phase;
               rsp_state_in  = current_state_ff;
               rsp_count_in  = fill_ff;
               rsp_last_in   = pick_last;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff           <= fsme_pkg::SEQ_IDLE;
         start_state_ff   <= '0;
         queue_limit_ff   <= fsme_pkg::QUEUE_LIMIT_RESET;
         current_state_ff <= '0;
         wr_ptr_ff        <= '0;
         rd_ptr_ff        <= '0;
         fill_ff          <= '0;
         pending_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         seq_ff           <= seq_in;
         start_state_ff   <= start_state_in;
         queue_limit_ff   <= queue_limit_in;
         current_state_ff <= current_state_in;
         wr_ptr_ff        <= wr_ptr_in;
         rd_ptr_ff        <= rd_ptr_in;
         fill_ff          <= fill_in;
         pending_ff       <= pending_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      changed_ff    <= changed_in;
      exit_ff       <= exit_in;
      tact_ff       <= tact_in;
      enter_ff      <= enter_in;
      rsp_status_ff <= rsp_status_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_phase_ff  <= rsp_phase_in;
      rsp_state_ff  <= rsp_state_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_action_code   = rsp_code_ff;
   assign rsp_action_phase  = rsp_phase_ff;
   assign rsp_current_state = rsp_state_ff;
   assign rsp_queue_count   = rsp_count_ff;
   assign rsp_last          = rsp_last_ff;

   `FSME_ASSERT(a_fill_bound, fill_ff <= LIMIT_CAP)
   `FSME_ASSERT(a_state_wrapped, int'(current_state_ff) < NUM_STATES)
   `FSME_ASSERT(a_emit_not_dry, (seq_ff != fsme_pkg::SEQ_EMIT) || (pending_ff != '0))
   `FSME_ASSERT_NEXT(a_step_starts, step_go, seq_ff == fsme_pkg::SEQ_QUEUE)

endmodule

[test/tb_table_driven_fsm_engine_top.sv]
module tb_table_driven_fsm_engine_top;
   import fsme_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;
   localparam int PTR_W = $clog2(QUEUE_DEPTH_DEF);
   localparam int IDX_W = STATE_W + EVENT_W;
   localparam int TABLE_SIZE = NUM_STATES_DEF * NUM_EVENTS_DEF;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_PHASES = 6;
   localparam int ITEMS_PER_PHASE = 18;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [EVENT_W-1:0]  event_code;
      logic [STATE_W-1:0]  state_index;
      logic [STATE_W-1:0]  target;
      logic [ACTION_W-1:0] trans_act;
      logic [ACTION_W-1:0] exit_act;
      logic [ACTION_W-1:0] enter_act;
   } request_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ACTION_W-1:0] action_code;
      logic [PHASE_W-1:0]  action_phase;
      logic [STATE_W-1:0]  current_state;
      logic [COUNT_W-1:0]  queue_count;
      logic                last;
   } response_type;

   typedef struct packed {
      logic [ACTION_W-1:0] code;
      logic [PHASE_W-1:0]  phase;
   } action_type;

   class action_scoreboard;
      logic [STATE_W-1:0]  start_state;
      logic [COUNT_W-1:0]  queue_limit;
      logic [STATE_W-1:0]  cur_state;
      logic [EVENT_W-1:0]  slots [QUEUE_DEPTH_DEF];
      bit                  slot_written [QUEUE_DEPTH_DEF];
      logic [PTR_W-1:0]    wr_ptr;
      logic [PTR_W-1:0]    rd_ptr;
      logic [COUNT_W-1:0]  fill;
      logic [STATE_W-1:0]  trans_next [TABLE_SIZE];
      logic [ACTION_W-1:0] trans_act [TABLE_SIZE];
      bit                  trans_written [TABLE_SIZE];
      logic [ACTION_W-1:0] exit_act [NUM_STATES_DEF];
      logic [ACTION_W-1:0] enter_act [NUM_STATES_DEF];
      bit                  state_written [NUM_STATES_DEF];
      response_type        pending_actions [$];
      int                  errors;

      function new();
         start_state = '0;
         queue_limit = QUEUE_LIMIT_RESET;
         cur_state = '0;
         wr_ptr = '0;
         rd_ptr = '0;
         fill = '0;
         errors = 0;
         foreach (slots[i]) begin
            slots[i] = '0;
            slot_written[i] = 1'b0;
         end
         foreach (trans_next[i]) begin
            trans_next[i] = '0;
            trans_act[i] = '0;
            trans_written[i] = 1'b0;
         end
         foreach (exit_act[i]) begin
            exit_act[i] = '0;
            enter_act[i] = '0;
            state_written[i] = 1'b0;
         end
      endfunction

      function void configure(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         if (index == CSR_START_STATE) begin
            start_state = data[STATE_W-1:0];
         end else begin
            queue_limit = data;
         end
      endfunction

      function void note_request(request_type r);
         logic [COUNT_W-1:0] lim;
         logic [STATE_W-1:0] cur;
         logic [STATE_W-1:0] nxt;
         logic [IDX_W-1:0]   idx;
         status_type         st;
         action_type         acts [$];
         response_type       res;
         if (queue_limit == '0) lim = COUNT_W'(1);
         else if (queue_limit > COUNT_W'(QUEUE_DEPTH_DEF)) lim = COUNT_W'(QUEUE_DEPTH_DEF);
         else lim = queue_limit;
         st = STATUS_DONE;
         cur = cur_state;
         case (r.op)
            OP_ENQUEUE: begin
               if (fill < lim) begin
                  slots[wr_ptr] = r.event_code;
                  slot_written[wr_ptr] = 1'b1;
                  wr_ptr = ({1'b0, wr_ptr} + 5'd1 >= lim) ? '0 : wr_ptr + 1'b1;
                  fill = fill + 1'b1;
               end else begin
                  st = STATUS_FULL;
               end
            end
            OP_STEP: begin
               if (fill == '0) begin
                  st = STATUS_EMPTY;
               end else begin
                  idx = {cur, slots[rd_ptr]};
                  nxt = trans_next[idx];
                  rd_ptr = ({1'b0, rd_ptr} + 5'd1 >= lim) ? '0 : rd_ptr + 1'b1;
                  fill = fill - 1'b1;
                  cur_state = nxt;
                  if (nxt != cur && exit_act[cur] != '0)
                     acts.push_back('{exit_act[cur], PHASE_EXIT});
                  if (trans_act[idx] != '0)
                     acts.push_back('{trans_act[idx], PHASE_TRANS});
                  if (nxt != cur && enter_act[nxt] != '0)
                     acts.push_back('{enter_act[nxt], PHASE_ENTER});
               end
            end
            OP_WRITE_TRANS: begin
               idx = {r.state_index, r.event_code};
               trans_next[idx] = r.target;
               trans_act[idx] = r.trans_act;
               trans_written[idx] = 1'b1;
            end
            OP_WRITE_STATE: begin
               exit_act[r.state_index] = r.exit_act;
               enter_act[r.state_index] = r.enter_act;
               state_written[r.state_index] = 1'b1;
            end
            OP_RESTART: begin
               cur_state = start_state;
               wr_ptr = '0;
               rd_ptr = '0;
               fill = '0;
            end
            default: ;
         endcase
         if (acts.size() == 0) acts.push_back('{'0, PHASE_NONE});
         foreach (acts[i]) begin
            res.status = st;
            res.action_code = acts[i].code;
            res.action_phase = acts[i].phase;
            res.current_state = cur_state;
            res.queue_count = fill;
            res.last = (i == acts.size() - 1);
            pending_actions.push_back(res);
         end
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_response(response_type got);
         response_type want;
         if (pending_actions.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            return;
         end
         want = pending_actions.pop_front();
         compare_field("status", 8'(want.status), 8'(got.status));
         compare_field("action_code", 8'(want.action_code), 8'(got.action_code));
         compare_field("action_phase", 8'(want.action_phase), 8'(got.action_phase));
         compare_field("current_state", 8'(want.current_state), 8'(got.current_state));
         compare_field("queue_count", 8'(want.queue_count), 8'(got.queue_count));
         compare_field("last", 8'(want.last), 8'(got.last));
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [OP_W-1:0]        req_operation = '0;
   logic [EVENT_W-1:0]     req_event_req = '0;
   logic [STATE_W-1:0]     req_state_index = '0;
   logic [STATE_W-1:0]     req_target_state = '0;
   logic [ACTION_W-1:0]    req_transition_action = '0;
   logic [ACTION_W-1:0]    req_exit_action = '0;
   logic [ACTION_W-1:0]    req_enter_action = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [STATUS_W-1:0]    rsp_status;
   logic [ACTION_W-1:0]    rsp_action_code;
   logic [PHASE_W-1:0]     rsp_action_phase;
   logic [STATE_W-1:0]     rsp_current_state;
   logic [COUNT_W-1:0]     rsp_queue_count;
   logic                   rsp_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   action_scoreboard sb = new();
   request_type      script [$];
   response_type     seen;
   int               quiet_cycles = 0;
   int               stall_mode = 0;
   int               stall_left = 0;
   int               beat = 0;

   logic [CSR_DATA_W-1:0] phase_start [RANDOM_PHASES] = '{5'd4, 5'd0, 5'd31, 5'd10, 5'd7, 5'd0};
   logic [CSR_DATA_W-1:0] phase_limit [RANDOM_PHASES] = '{5'd4, 5'd1, 5'd0, 5'd31, 5'd16, 5'd0};
   int                    phase_enq [RANDOM_PHASES] = '{45, 40, 40, 65, 55, 50};

   table_driven_fsm_engine_top DUT (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      beat <= beat + 1;
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(8, 40);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 1);
         default: rsp_ready <= (beat % 4 == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen.status = rsp_status;
         seen.action_code = rsp_action_code;
         seen.action_phase = rsp_action_phase;
         seen.current_state = rsp_current_state;
         seen.queue_count = rsp_queue_count;
         seen.last = rsp_last;
         sb.check_response(seen);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [ACTION_W-1:0] random_action();
      if ($urandom_range(0, 3) == 0) return '0;
      return ACTION_W'($urandom);
   endfunction

   function automatic request_type make_item(logic [OP_W-1:0] op, logic [EVENT_W-1:0] ev,
                                             logic [STATE_W-1:0] si, logic [STATE_W-1:0] tgt,
                                             logic [ACTION_W-1:0] ta, logic [ACTION_W-1:0] xa,
                                             logic [ACTION_W-1:0] na);
      request_type item;
      item.op = op;
      item.event_code = ev;
      item.state_index = si;
      item.target = tgt;
      item.trans_act = ta;
      item.exit_act = xa;
      item.enter_act = na;
      return item;
   endfunction

   // steps are only issued once every table entry they read has been loaded
   function automatic request_type next_random_item(int enq_pct);
      request_type      item;
      int               roll;
      logic [IDX_W-1:0] idx;
      logic [STATE_W-1:0] nxt;
      item.event_code = EVENT_W'($urandom);
      item.state_index = STATE_W'($urandom);
      item.target = STATE_W'($urandom);
      item.trans_act = random_action();
      item.exit_act = random_action();
      item.enter_act = random_action();
      roll = $urandom_range(0, 99);
      if (roll < enq_pct) begin
         item.op = OP_ENQUEUE;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 60) item.op = OP_STEP;
         else if (roll < 78) item.op = OP_WRITE_TRANS;
         else if (roll < 92) item.op = OP_WRITE_STATE;
         else if (roll < 96) item.op = OP_RESTART;
         else item.op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      end
      if (item.op == OP_STEP && sb.fill != '0) begin
         if (!sb.slot_written[sb.rd_ptr]) begin
            item.op = OP_RESTART;
         end else begin
            idx = {sb.cur_state, sb.slots[sb.rd_ptr]};
            nxt = sb.trans_next[idx];
            if (!sb.trans_written[idx]) begin
               item.op = OP_WRITE_TRANS;
               item.state_index = sb.cur_state;
               item.event_code = sb.slots[sb.rd_ptr];
            end else if (!sb.state_written[sb.cur_state]) begin
               item.op = OP_WRITE_STATE;
               item.state_index = sb.cur_state;
            end else if (!sb.state_written[nxt]) begin
               item.op = OP_WRITE_STATE;
               item.state_index = nxt;
            end
         end
      end
      return item;
   endfunction

   task automatic drive_items(int count, int enq_pct);
      request_type item;
      int          burst_left;
      int          gap;
      burst_left = $urandom_range(1, 8);
      for (int n = 0; n < count; n++) begin
         item = (script.size() != 0) ? script.pop_front() : next_random_item(enq_pct);
         req_operation <= item.op;
         req_event_req <= item.event_code;
         req_state_index <= item.state_index;
         req_target_state <= item.target;
         req_transition_action <= item.trans_act;
         req_exit_action <= item.exit_act;
         req_enter_action <= item.enter_act;
         req_valid <= 1'b1;
         do @(posedge clock); while (!req_ready);
         sb.note_request(item);
         burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      req_valid <= 1'b0;
   endtask

   task automatic write_config(logic [CSR_DATA_W-1:0] start_wd, logic [CSR_DATA_W-1:0] limit_wd);
      logic [CSR_INDEX_W-1:0] idx [2];
      logic [CSR_DATA_W-1:0]  val [2];
      idx[0] = CSR_START_STATE;
      idx[1] = CSR_QUEUE_LIMIT;
      val[0] = start_wd;
      val[1] = limit_wd;
      for (int i = 0; i < 2; i++) begin
         csr_index <= idx[i];
         csr_wdata <= val[i];
         csr_valid <= 1'b1;
         do @(posedge clock); while (!csr_ready);
         sb.configure(idx[i], val[i]);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (sb.pending_actions.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      script.push_back(make_item(OP_STEP, 0, 0, 0, 0, 0, 0));
      script.push_back(make_item(OP_UNUSED_LO, 0, 0, 0, 0, 0, 0));
      script.push_back(make_item(OP_UNUSED_HI, 0, 0, 0, 0, 0, 0));
      script.push_back(make_item(OP_WRITE_STATE, 0, 0, 0, 0, 63, 0));
      script.push_back(make_item(OP_WRITE_STATE, 0, 15, 0, 0, 0, 63));
      script.push_back(make_item(OP_WRITE_TRANS, 15, 0, 15, 63, 0, 0));
      script.push_back(make_item(OP_WRITE_TRANS, 0, 15, 15, 0, 0, 0));
      script.push_back(make_item(OP_WRITE_TRANS, 15, 15, 0, 0, 0, 0));
      script.push_back(make_item(OP_WRITE_TRANS, 0, 0, 0, 1, 0, 0));
      script.push_back(make_item(OP_ENQUEUE, 15, 0, 0, 0, 0, 0));
      script.push_back(make_item(OP_ENQUEUE, 0, 0, 0, 0, 0, 0));
      script.push_back(make_item(OP_ENQUEUE, 15, 0, 0, 0, 0, 0));
      script.push_back(make_item(OP_ENQUEUE, 0, 0, 0, 0, 0, 0));
      // exit/transition/enter, self with no action, change with no action, self action
      repeat (4) script.push_back(make_item(OP_STEP, 0, 0, 0, 0, 0, 0));
      script.push_back(make_item(OP_STEP, 0, 0, 0, 0, 0, 0));
      script.push_back(make_item(OP_RESTART, 0, 0, 0, 0, 0, 0));
      // leave the queue fuller than the next limit
      repeat (6) script.push_back(make_item(OP_ENQUEUE, 0, 0, 0, 0, 0, 0));
      write_config(5'd15, 5'd16);
      drive_items(script.size(), 50);
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_idle();
         if (p == RANDOM_PHASES - 1) begin
            write_config(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom));
         end else begin
            write_config(phase_start[p], phase_limit[p]);
         end
         drive_items(ITEMS_PER_PHASE, phase_enq[p]);
      end
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/fsme_pkg.sv
hw/rtl/fsme_ram.sv
hw/rtl/table_driven_fsm_engine_top.sv
test/tb_table_driven_fsm_engine_top.sv
